FILE: rtl/core/utf16_byte_stream_decoder_top_assert.svh
// Assertion macros shared by the decoder modules; each assumes clk and rst_n in scope.
`ifndef UTF16_BYTE_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF16_BYTE_STREAM_DECODER_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define U16D_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define U16D_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define U16D_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/u16d_pkg.sv
// Shared constants and types of the UTF-16 byte stream decoder.
package u16d_pkg;

  // Stream length the unit counter is sized for; the count saturates at half of it.
  localparam int unsigned MAX_STREAM_BYTES = 65536;
  localparam int unsigned COUNT_LIMIT_INT =
    ((MAX_STREAM_BYTES / 2) > 65535) ? 65535 : (MAX_STREAM_BYTES / 2);
  localparam logic [15:0] COUNT_LIMIT = 16'(COUNT_LIMIT_INT);

  // Code units with special meaning.
  localparam logic [15:0] UNIT_CR   = 16'h000D;
  localparam logic [15:0] UNIT_LF   = 16'h000A;
  localparam logic [15:0] MARK_UNIT = 16'hFEFF;
  localparam logic [15:0] ASCII_MAX = 16'd127;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LITTLE_ENDIAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CRLF_TO_LF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DROP_BOM      = 2'd2;

  // Default depth of the command queue between front and back.
  localparam int unsigned CMD_DEPTH_DEF = 4;

  // One command: which results a byte causes, in the order LF, unit, summary.
  typedef struct packed {
    logic        emit_lf;
    logic        emit_unit;
    logic        summary;
    logic [15:0] unit;
  } cmd_t;

endpackage

FILE: rtl/core/u16d_front.sv
// Front part: configuration registers, byte pairing and line-ending classification.
module u16d_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [u16d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [u16d_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_accept,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           cmd_push,
  output u16d_pkg::cmd_t                 cmd
);
  import u16d_pkg::*;

  logic        little_endian_r, little_endian_nxt;
  logic        crlf_to_lf_r, crlf_to_lf_nxt;
  logic        drop_bom_r, drop_bom_nxt;
  logic        byte_pending_r, byte_pending_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        expect_lf_r, expect_lf_nxt;
  logic        at_first_r, at_first_nxt;

  logic [15:0] unit;
  logic        keep_raw;
  logic        hold_cr;
  logic        emit_lf;
  logic        emit_unit;

  // Register writes.
  always_comb begin
    little_endian_nxt = little_endian_r;
    crlf_to_lf_nxt    = crlf_to_lf_r;
    drop_bom_nxt      = drop_bom_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_LITTLE_ENDIAN: little_endian_nxt = cfg_data[0];
        CFG_IDX_CRLF_TO_LF:    crlf_to_lf_nxt    = cfg_data[0];
        CFG_IDX_DROP_BOM:      drop_bom_nxt      = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the byte: form a unit, drop a leading mark, withhold a CR.
  always_comb begin
    unit      = little_endian_r ? {in_data_byte, held_byte_r} : {held_byte_r, in_data_byte};
    keep_raw  = !(at_first_r && drop_bom_r && (unit == MARK_UNIT));
    hold_cr   = keep_raw && crlf_to_lf_r && (unit == UNIT_CR);
    emit_lf   = byte_pending_r && keep_raw && crlf_to_lf_r && expect_lf_r && (unit != UNIT_LF);
    emit_unit = byte_pending_r && keep_raw && !hold_cr;

    byte_pending_nxt = byte_pending_r;
    held_byte_nxt    = held_byte_r;
    expect_lf_nxt    = expect_lf_r;
    at_first_nxt     = at_first_r;
    if (in_accept) begin
      if (!byte_pending_r) begin
        held_byte_nxt    = in_data_byte;
        byte_pending_nxt = 1'b1;
      end else begin
        byte_pending_nxt = 1'b0;
        at_first_nxt     = 1'b0;
        if (keep_raw && crlf_to_lf_r) begin
          expect_lf_nxt = (unit == UNIT_CR);
        end
      end
      // End of stream returns the stream state to its reset values.
      if (in_last_byte) begin
        byte_pending_nxt = 1'b0;
        expect_lf_nxt    = 1'b0;
        at_first_nxt     = 1'b1;
      end
    end
  end

  assign cmd_push      = in_accept && (emit_lf || emit_unit || in_last_byte);
  assign cmd.emit_lf   = emit_lf;
  assign cmd.emit_unit = emit_unit;
  assign cmd.summary   = in_last_byte;
  assign cmd.unit      = unit;

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      little_endian_r <= 1'b1;
      crlf_to_lf_r    <= 1'b0;
      drop_bom_r      <= 1'b1;
      byte_pending_r  <= 1'b0;
      expect_lf_r     <= 1'b0;
      at_first_r      <= 1'b1;
    end else begin
      little_endian_r <= little_endian_nxt;
      crlf_to_lf_r    <= crlf_to_lf_nxt;
      drop_bom_r      <= drop_bom_nxt;
      byte_pending_r  <= byte_pending_nxt;
      expect_lf_r     <= expect_lf_nxt;
      at_first_r      <= at_first_nxt;
    end
  end

  // Held byte is payload and needs no reset.
  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule

FILE: rtl/core/u16d_cmdq.sv
// Command queue between the front and back parts.
module u16d_cmdq #(
  parameter int unsigned DEPTH = u16d_pkg::CMD_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u16d_pkg::cmd_t push_cmd,
  input  logic           pop,
  output u16d_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);
  import u16d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`include "utf16_byte_stream_decoder_top_assert.svh"

  `U16D_ASSERT_ALWAYS(a_cmdq_count_bound, count_r <= CNT_W'(DEPTH), "queue count exceeds depth")
  `U16D_ASSERT_SAME(a_cmdq_no_pop_empty, pop, count_r != '0, "command popped from empty queue")
  `U16D_ASSERT_NEXT(a_cmdq_push_grows, push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")

endmodule

FILE: rtl/core/u16d_back.sv
// Back part: expands commands into result items and keeps the running statistics.
module u16d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  u16d_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [15:0]    out_code_unit,
  output logic           out_is_summary,
  output logic           out_all_ascii,
  output logic [15:0]    out_unit_count
);
  import u16d_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] code_unit_r;
  logic        is_summary_r;
  logic        all_ascii_r;
  logic [15:0] unit_count_r;
  logic        lf_done_r, lf_done_nxt;
  logic        unit_done_r, unit_done_nxt;
  logic        ascii_so_far_r, ascii_so_far_nxt;
  logic [15:0] emitted_units_r, emitted_units_nxt;

  logic        load;
  logic        go;
  logic        sel_lf;
  logic        sel_unit;
  logic        last_slot;
  logic [15:0] res_unit;
  logic        res_ascii;
  logic [15:0] res_count;

  // Pick the next result of the head command: LF first, then the unit, then the summary.
  always_comb begin
    load      = !out_valid_r || out_pop;
    go        = load && !cmd_empty;
    sel_lf    = cmd.emit_lf && !lf_done_r;
    sel_unit  = !sel_lf && cmd.emit_unit && !unit_done_r;
    if (sel_lf) begin
      last_slot = !cmd.emit_unit && !cmd.summary;
      res_unit  = UNIT_LF;
    end else if (sel_unit) begin
      last_slot = !cmd.summary;
      res_unit  = cmd.unit;
    end else begin
      last_slot = 1'b1;
      res_unit  = '0;
    end
  end

  // Statistics as shown on the item: updated for a unit, current for a summary.
  always_comb begin
    if (sel_lf || sel_unit) begin
      res_ascii = ascii_so_far_r && (res_unit <= ASCII_MAX);
      res_count = (emitted_units_r < COUNT_LIMIT) ? emitted_units_r + 16'd1 : emitted_units_r;
    end else begin
      res_ascii = ascii_so_far_r;
      res_count = emitted_units_r;
    end
  end

  // Next state of the sequencer and the running statistics.
  always_comb begin
    out_valid_nxt     = out_valid_r;
    lf_done_nxt       = lf_done_r;
    unit_done_nxt     = unit_done_r;
    ascii_so_far_nxt  = ascii_so_far_r;
    emitted_units_nxt = emitted_units_r;
    if (go) begin
      out_valid_nxt = 1'b1;
      if (last_slot) begin
        lf_done_nxt   = 1'b0;
        unit_done_nxt = 1'b0;
      end else begin
        lf_done_nxt   = lf_done_r || sel_lf;
        unit_done_nxt = unit_done_r || sel_unit;
      end
      if (sel_lf || sel_unit) begin
        ascii_so_far_nxt  = res_ascii;
        emitted_units_nxt = res_count;
      end else begin
        ascii_so_far_nxt  = 1'b1;
        emitted_units_nxt = '0;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cmd_pop        = go && last_slot;
  assign out_empty      = !out_valid_r;
  assign out_code_unit  = code_unit_r;
  assign out_is_summary = is_summary_r;
  assign out_all_ascii  = all_ascii_r;
  assign out_unit_count = unit_count_r;

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      lf_done_r       <= 1'b0;
      unit_done_r     <= 1'b0;
      ascii_so_far_r  <= 1'b1;
      emitted_units_r <= '0;
    end else begin
      out_valid_r     <= out_valid_nxt;
      lf_done_r       <= lf_done_nxt;
      unit_done_r     <= unit_done_nxt;
      ascii_so_far_r  <= ascii_so_far_nxt;
      emitted_units_r <= emitted_units_nxt;
    end
  end

  // Output item register.
  always_ff @(posedge clk) begin
    if (go) begin
      code_unit_r  <= res_unit;
      is_summary_r <= !(sel_lf || sel_unit);
      all_ascii_r  <= res_ascii;
      unit_count_r <= res_count;
    end
  end

`include "utf16_byte_stream_decoder_top_assert.svh"

  `U16D_ASSERT_ALWAYS(a_back_count_limit, emitted_units_r <= COUNT_LIMIT, "unit count above limit")
  `U16D_ASSERT_SAME(a_back_unit_counted, out_valid_r && !is_summary_r, unit_count_r != '0, "unit item with zero count")
  `U16D_ASSERT_NEXT(a_back_summary_clears, go && !sel_lf && !sel_unit, (emitted_units_r == '0) && ascii_so_far_r, "statistics not cleared after summary")

endmodule

FILE: rtl/core/utf16_byte_stream_decoder_top.sv
// Top level of the UTF-16 byte stream decoder with line-ending normalization.
//
// Bytes enter on the input queue port (in_push/in_full) with a last-byte mark.
// Pairs of bytes form 16-bit code units in the configured byte order; a leading
// 0xFEFF can be dropped, and CR or CRLF can be turned into a single LF.
// Result items leave on the output queue port (out_empty/out_pop): decoded units
// followed by one summary item per stream with the ASCII flag and unit count.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// A result is written into the command queue at the edge that accepts the byte
// causing it, then into the output register that drives the output ports.
// The front takes one byte per cycle unless in_full is set; the back gives one
// result per cycle unless the output stalls, so a byte causing an LF, a unit
// and a summary yields three results; the command queue absorbs such bursts.
// When the receiver stalls, the output register holds its item, the command
// queue fills and in_full rises; nothing is lost. Reset clears all stream
// state, empties the queue and restores the register defaults.
module utf16_byte_stream_decoder_top #(
  parameter int unsigned CMD_DEPTH = u16d_pkg::CMD_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [u16d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u16d_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [15:0]                     out_code_unit,
  output logic                            out_is_summary,
  output logic                            out_all_ascii,
  output logic [15:0]                     out_unit_count
);
  import u16d_pkg::*;

  logic in_accept;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign in_accept = in_push && !in_full;

  // Front: pairing and classification.
  u16d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_accept    (in_accept),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd)
  );

  // Queue between front and back.
  u16d_cmdq #(
    .DEPTH (CMD_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .full     (in_full),
    .empty    (cmd_empty)
  );

  // Back: result sequencing and statistics.
  u16d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (head_cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_code_unit  (out_code_unit),
    .out_is_summary (out_is_summary),
    .out_all_ascii  (out_all_ascii),
    .out_unit_count (out_unit_count)
  );

endmodule
